// File: sv/pbm_pkg.sv
// shared types, mode codes and arithmetic helpers for the pixel blend block
`default_nettype none
package pbm_pkg;

  typedef enum logic [2:0] {
    MODE_MULTIPLY = 3'd3,
    MODE_OVERLAY  = 3'd4,
    MODE_DODGE    = 3'd5,
    MODE_BURN     = 3'd6,
    MODE_LIGHTEN  = 3'd7
  } mode_t;

  localparam mode_t MODE_RESET = MODE_MULTIPLY;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned PIPE_DEPTH = 4;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CHAN_W-1:0] alpha;
  } ctrl_t;

  // one restoring step: shifts in a zero bit, returns {quotient bit, remainder}
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                               input logic [CHAN_W-1:0] d);
    logic [CHAN_W:0] r2;
    logic [CHAN_W:0] diff;
    r2 = {rem, 1'b0};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, diff[CHAN_W-1:0]};
    end else begin
      return {1'b0, r2[CHAN_W-1:0]};
    end
  endfunction

  // floor(x / 255) for x below 2*255*255, result known to fit a channel
  function automatic logic [CHAN_W-1:0] div255(input logic [16:0] x);
    logic [17:0] s;
    logic [9:0]  q1;
    logic [17:0] prod;
    logic [17:0] r;
    logic [9:0]  q1_inc;
    s = {1'b0, x} + {9'b0, x[16:8]};
    q1 = s[17:8];
    prod = {q1, 8'b0} - {8'b0, q1};
    r = {1'b0, x} - prod;
    q1_inc = q1 + 10'd1;
    if (r >= 18'd255) begin
      return q1_inc[CHAN_W-1:0];
    end else begin
      return q1[CHAN_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/pbm_lane.sv
// one color channel lane: multiplier path, divide-by-255 and pipelined quotient divider
`default_nettype none
module pbm_lane (
  input  logic                       clk,
  input  logic [pbm_pkg::CHAN_W-1:0] a,
  input  logic [pbm_pkg::CHAN_W-1:0] b,
  input  pbm_pkg::mode_t             mode,
  output logic [pbm_pkg::CHAN_W-1:0] y
);
  import pbm_pkg::*;

  logic              flip;
  logic [CHAN_W-1:0] ma, mb;
  logic [15:0]       prod;
  logic [16:0]       x_next;
  logic [CHAN_W-1:0] dn, dd;
  logic [CHAN_W:0]   st0, st1, st2, st3, st4, st5, st6, st7;

  // stage 1
  logic [16:0]       s1_x;
  logic [CHAN_W-1:0] s1_rem, s1_d, s1_max;
  logic [1:0]        s1_q;
  logic              s1_sat, s1_hi;
  mode_t             s1_mode;
  // stage 2
  logic [CHAN_W-1:0] s2_mul, s2_rem, s2_d, s2_max;
  logic [3:0]        s2_q;
  logic              s2_sat, s2_hi;
  mode_t             s2_mode;
  // stage 3
  logic [CHAN_W-1:0] s3_mul, s3_rem, s3_d, s3_max;
  logic [5:0]        s3_q;
  logic              s3_sat, s3_hi;
  mode_t             s3_mode;
  // stage 4
  logic [CHAN_W-1:0] s4_mul, s4_max;
  logic [7:0]        s4_q;
  logic              s4_sat, s4_hi;
  mode_t             s4_mode;

  always_comb begin
    flip = (mode == MODE_OVERLAY) && a[CHAN_W-1];
    ma = flip ? ~a : a;
    mb = flip ? ~b : b;
    prod = {8'b0, ma} * {8'b0, mb};
    x_next = (mode == MODE_OVERLAY) ? {prod, 1'b0} : {1'b0, prod};
    // dodge divides a by 255-b, burn divides 255-a by b
    dn = (mode == MODE_DODGE) ? a : ~a;
    dd = (mode == MODE_DODGE) ? ~b : b;
    st0 = div_step(dn, dd);
    st1 = div_step(st0[CHAN_W-1:0], dd);
    st2 = div_step(s1_rem, s1_d);
    st3 = div_step(st2[CHAN_W-1:0], s1_d);
    st4 = div_step(s2_rem, s2_d);
    st5 = div_step(st4[CHAN_W-1:0], s2_d);
    st6 = div_step(s3_rem, s3_d);
    st7 = div_step(st6[CHAN_W-1:0], s3_d);
  end

  always_ff @(posedge clk) begin
    s1_x    <= x_next;
    s1_rem  <= st1[CHAN_W-1:0];
    s1_q    <= {st0[CHAN_W], st1[CHAN_W]};
    s1_d    <= dd;
    s1_sat  <= dn >= dd;
    s1_hi   <= a[CHAN_W-1];
    s1_max  <= (b > a) ? b : a;
    s1_mode <= mode;

    s2_mul  <= div255(s1_x);
    s2_rem  <= st3[CHAN_W-1:0];
    s2_q    <= {s1_q, st2[CHAN_W], st3[CHAN_W]};
    s2_d    <= s1_d;
    s2_sat  <= s1_sat;
    s2_hi   <= s1_hi;
    s2_max  <= s1_max;
    s2_mode <= s1_mode;

    s3_mul  <= s2_mul;
    s3_rem  <= st5[CHAN_W-1:0];
    s3_q    <= {s2_q, st4[CHAN_W], st5[CHAN_W]};
    s3_d    <= s2_d;
    s3_sat  <= s2_sat;
    s3_hi   <= s2_hi;
    s3_max  <= s2_max;
    s3_mode <= s2_mode;

    s4_mul  <= s3_mul;
    s4_q    <= {s3_q, st6[CHAN_W], st7[CHAN_W]};
    s4_sat  <= s3_sat;
    s4_hi   <= s3_hi;
    s4_max  <= s3_max;
    s4_mode <= s3_mode;
  end

  always_comb begin
    unique case (s4_mode)
      MODE_MULTIPLY: y = s4_mul;
      MODE_OVERLAY:  y = s4_hi ? ~s4_mul : s4_mul;
      MODE_DODGE:    y = s4_sat ? 8'hff : s4_q;
      MODE_BURN:     y = s4_sat ? 8'h00 : ~s4_q;
      MODE_LIGHTEN:  y = s4_max;
      default:       y = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/pixel_blend_modes.sv
// top level: mode register, three channel lanes and the output merge register
// One pixel pair is taken every clock and busy never rises. Each result appears
// on done for one cycle, registered behind the four lane stages and the output
// merge register, and the receiver cannot stall it. The four lane stages hold the
// dodge and burn quotient divider, which resolves two quotient bits per pipeline
// stage, and the output register merges the lanes with the base alpha and last flag.
`default_nettype none
module pixel_blend_modes (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] base_pixel,
  input  logic [31:0] blend_pixel,
  input  logic        in_last,
  input  logic        blend_mode_we,
  input  logic [2:0]  blend_mode_wdata,
  output logic        done,
  output logic [31:0] out_pixel,
  output logic        out_last
);
  import pbm_pkg::*;

  mode_t             mode;
  ctrl_t             pipe [PIPE_DEPTH];
  logic [CHAN_W-1:0] lane_y [NUM_LANES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (blend_mode_we) begin
      mode <= mode_t'(blend_mode_wdata);
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    pbm_lane u_lane (
      .clk  (clk),
      .a    (base_pixel[i*CHAN_W +: CHAN_W]),
      .b    (blend_pixel[i*CHAN_W +: CHAN_W]),
      .mode (mode),
      .y    (lane_y[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        pipe[i] <= '0;
      end
      done <= 1'b0;
    end else begin
      pipe[0] <= '{valid: start && !busy, last: in_last, alpha: base_pixel[31:24]};
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        pipe[i] <= pipe[i-1];
      end
      done <= pipe[PIPE_DEPTH-1].valid;
    end
  end

  // merge stage
  always_ff @(posedge clk) begin
    out_pixel <= {pipe[PIPE_DEPTH-1].alpha, lane_y[2], lane_y[1], lane_y[0]};
    out_last  <= pipe[PIPE_DEPTH-1].last;
  end

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 done)
    else $error("request produced no result after five cycles");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> out_pixel[31:24] == $past(base_pixel[31:24], 5))
    else $error("result alpha does not match base alpha");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> out_last == $past(in_last, 5))
    else $error("last flag misaligned");

endmodule
`default_nettype wire

// File: dv/pixel_blend_modes_tb.sv
// testbench for pixel_blend_modes: directed table and random pixel pairs checked per result
module pixel_blend_modes_tb;
  import pbm_pkg::*;

  localparam logic [2:0] MODE_OFF_0 = 3'd0;
  localparam logic [2:0] MODE_OFF_1 = 3'd1;
  localparam logic [2:0] MODE_OFF_2 = 3'd2;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_PHASES = 17;
  localparam int unsigned PHASE_PIXELS = 50;
  localparam int unsigned NUM_CASES = 18;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } blend_result_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] base;
    logic [31:0] blend;
    logic        last;
    logic        typed;
    logic [31:0] pixel;
  } pixel_case_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] base_pixel;
  logic [31:0] blend_pixel;
  logic        in_last;
  logic        blend_mode_we;
  logic [2:0]  blend_mode_wdata;
  logic        done;
  logic [31:0] out_pixel;
  logic        out_last;

  blend_result_t pending_pixels[$];
  logic [2:0]    mode_now;
  int unsigned   mismatches;
  int unsigned   cycles;

  pixel_blend_modes dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .base_pixel       (base_pixel),
    .blend_pixel      (blend_pixel),
    .in_last          (in_last),
    .blend_mode_we    (blend_mode_we),
    .blend_mode_wdata (blend_mode_wdata),
    .done             (done),
    .out_pixel        (out_pixel),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] blend_channel(input logic [2:0] mode, input logic [7:0] a,
                                               input logic [7:0] b);
    int ia;
    int ib;
    int v;
    ia = a;
    ib = b;
    case (mode)
      MODE_MULTIPLY: begin
        v = (ia * ib) / 255;
      end
      MODE_OVERLAY: begin
        if (ia < 128) v = (2 * ib * ia) / 255;
        else v = 255 - (2 * (255 - ib) * (255 - ia)) / 255;
      end
      MODE_DODGE: begin
        if (ib == 255) v = 255;
        else v = (ia * 256) / (255 - ib);
        if (v > 255) v = 255;
      end
      MODE_BURN: begin
        if (ib == 0) v = 0;
        else v = 255 - ((255 - ia) * 256) / ib;
        if (v < 0) v = 0;
      end
      MODE_LIGHTEN: begin
        v = (ib > ia) ? ib : ia;
      end
      default: begin
        v = 0;
      end
    endcase
    return v[7:0];
  endfunction

  function automatic blend_result_t blend_pixels(input logic [31:0] base, input logic [31:0] blend,
                                                 input logic last);
    blend_result_t r;
    r.pixel = {base[31:24], blend_channel(mode_now, base[23:16], blend[23:16]),
               blend_channel(mode_now, base[15:8], blend[15:8]),
               blend_channel(mode_now, base[7:0], blend[7:0])};
    r.last = last;
    return r;
  endfunction

  // channel values lean toward the mode boundaries
  function automatic logic [7:0] pick_channel();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = 8'h00;
      1: c = 8'hff;
      2: c = $urandom_range(0, 1) ? 8'h7f : 8'h80;
      3: c = $urandom_range(0, 1) ? 8'hfe : 8'h01;
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_pixel();
    logic [31:0] p;
    logic [7:0]  alpha;
    alpha = 8'($urandom);
    if ($urandom_range(0, 3) == 0) p = $urandom;
    else p = {alpha, pick_channel(), pick_channel(), pick_channel()};
    return p;
  endfunction

  task automatic send_pixel(input logic [31:0] base, input logic [31:0] blend, input logic last,
                            input blend_result_t want);
    @(negedge clk);
    start <= 1'b1;
    base_pixel <= base;
    blend_pixel <= blend;
    in_last <= last;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(want);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic [2:0] mode);
    drain_pixels();
    blend_mode_we <= 1'b1;
    blend_mode_wdata <= mode;
    @(negedge clk);
    blend_mode_we <= 1'b0;
    mode_now = mode;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pixel_blend_modes verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    blend_result_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel %h last %b", out_pixel, out_last);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                     want.pixel, want.last, out_pixel, out_last);
        end
      end
    end
  end

  initial begin
    pixel_case_t   cases [NUM_CASES];
    blend_result_t want;
    logic [31:0]   base;
    logic [31:0]   blend;
    logic          last;
    int unsigned   gap_pct;

    cases = '{
      '{MODE_MULTIPLY, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
      '{MODE_MULTIPLY, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 32'h00000000},
      '{MODE_MULTIPLY, 32'hff80ff01, 32'h00ff0080, 1'b0, 1'b0, 32'h0},
      '{MODE_OVERLAY,  32'h007f8000, 32'h00ffffff, 1'b1, 1'b0, 32'h0},
      '{MODE_OVERLAY,  32'hffffffff, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{MODE_OVERLAY,  32'h5a807f01, 32'h80fe0180, 1'b0, 1'b0, 32'h0},
      '{MODE_DODGE,    32'h12000000, 32'h00ffffff, 1'b0, 1'b1, 32'h12ffffff},
      '{MODE_DODGE,    32'h00ffffff, 32'h00fefe00, 1'b1, 1'b0, 32'h0},
      '{MODE_DODGE,    32'h00000000, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{MODE_BURN,     32'h34ffffff, 32'hff000000, 1'b0, 1'b1, 32'h34000000},
      '{MODE_BURN,     32'h00000000, 32'h00ffff01, 1'b1, 1'b0, 32'h0},
      '{MODE_BURN,     32'h00ff80ff, 32'h0001ff01, 1'b0, 1'b0, 32'h0},
      '{MODE_LIGHTEN,  32'h00102030, 32'hff302010, 1'b0, 1'b1, 32'h00302030},
      '{MODE_LIGHTEN,  32'hffffffff, 32'h00000000, 1'b1, 1'b1, 32'hffffffff},
      '{MODE_OFF_0,    32'hab123456, 32'hffffffff, 1'b0, 1'b1, 32'hab000000},
      '{MODE_OFF_1,    32'h00ffffff, 32'hffffffff, 1'b1, 1'b1, 32'h00000000},
      '{MODE_OFF_2,    32'hffffffff, 32'h12345678, 1'b0, 1'b1, 32'hff000000},
      '{MODE_MULTIPLY, 32'h5a808080, 32'h80808080, 1'b1, 1'b0, 32'h0}
    };

    mismatches = 0;
    cycles = 0;
    mode_now = MODE_RESET;
    rst = 1'b1;
    start = 1'b0;
    base_pixel = '0;
    blend_pixel = '0;
    in_last = 1'b0;
    blend_mode_we = 1'b0;
    blend_mode_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NUM_CASES; i++) begin
      if (cases[i].mode != mode_now) write_mode(cases[i].mode);
      if (cases[i].typed) want = '{cases[i].pixel, cases[i].last};
      else want = blend_pixels(cases[i].base, cases[i].blend, cases[i].last);
      send_pixel(cases[i].base, cases[i].blend, cases[i].last, want);
    end

    // random phases, one mode each
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 8) write_mode(3'(phase));
      else write_mode(3'($urandom_range(0, 7)));
      gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 50);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (phase % 4 == 1 && n == PHASE_PIXELS / 2) drain_pixels();
        base = pick_pixel();
        blend = pick_pixel();
        last = 1'($urandom_range(0, 1));
        send_pixel(base, blend, last, blend_pixels(base, blend, last));
        if ($urandom_range(1, 100) <= gap_pct) begin
          if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(20, 60));
          else idle_cycles($urandom_range(1, 3));
        end
      end
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("pixel_blend_modes verification clean");
    end else begin
      $display("pixel_blend_modes verification failed");
    end
    $finish;
  end

endmodule
